[hw/rtl/reeu_pkg.sv]
// Shared constants, codes and helpers for the rotary encoder event unit.
package reeu_pkg;

    localparam int NUM_ENC = 2;
    localparam int ENC_W   = 1;

    localparam int STEPS_W = 4;
    localparam int TICKS_W = 24;
    localparam int CFG_W   = 24;

    localparam logic [STEPS_W-1:0] STEPS_RST = 4'd4;
    localparam logic [TICKS_W-1:0] TICKS_RST = 24'd200000;
    localparam logic [STEPS_W-1:0] COUNT_MAX = 4'd15;

    // register indexes
    localparam logic CFG_IDX_STEPS   = 1'b0;
    localparam logic CFG_IDX_LOCKOUT = 1'b1;

    // request types
    localparam logic [1:0] REQ_PHASE = 2'd0;
    localparam logic [1:0] REQ_PRESS = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // event kinds
    localparam logic [1:0] KIND_SWITCH = 2'd0;
    localparam logic [1:0] KIND_CW     = 2'd1;
    localparam logic [1:0] KIND_CCW    = 2'd2;

    // next code in the forward Gray sequence 00->01->11->10->00
    function automatic logic [1:0] next_fwd(input logic [1:0] code);
        logic [1:0] nxt;
        case (code)
            2'd0:    nxt = 2'd1;
            2'd1:    nxt = 2'd3;
            2'd3:    nxt = 2'd2;
            default: nxt = 2'd0;
        endcase
        return nxt;
    endfunction

    function automatic logic [STEPS_W-1:0] bump(input logic [STEPS_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
    endfunction

endpackage

[hw/rtl/rotary_encoder_event_unit.sv]
// Rotary encoder event unit: quadrature decode, step counting, switch lockout.
//
// Takes one request per clock on s_axis, unless m_axis back-pressure stalls
// it: phase changes and switch presses for reeu_pkg::NUM_ENC encoders, plus
// time ticks for the shared switch lockout. Each request passes an input
// register and then a result register before its result appears on m_axis,
// and a new request can be taken while the last is still in the result
// register. A request that produces no event still moves through both stages
// but leaves nothing on m_axis. The combinational update of the per-encoder
// counts between the two registers sets the rate; back-pressure from
// m_axis_tready reaches s_axis_tready in the same cycle, so a stalled result
// register holds one request back in the input register and no more.
// Counts saturate at 15 and a steps register of zero behaves as one; a press
// during lockout is dropped without restarting it. Configuration writes on the
// i_cfg port take effect at once and are meant for idle periods only.
module rotary_encoder_event_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [reeu_pkg::CFG_W-1:0] i_cfg_data,
    // requests
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [0] encoder_id, [2:1] phase_code
    input  logic [1:0]                 s_axis_tuser,   // [1:0] req_type
    // events
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [0] event_encoder
    output logic [1:0]                 m_axis_tuser    // [1:0] event_kind
);

    // configuration registers
    logic [reeu_pkg::STEPS_W-1:0] r_steps;
    logic [reeu_pkg::TICKS_W-1:0] r_ticks;

    // input stage
    logic                         r_in_valid;
    logic [1:0]                   r_in_type;
    logic [reeu_pkg::ENC_W-1:0]   r_in_enc;
    logic [1:0]                   r_in_code;

    // result stage
    logic                         r_out_valid;
    logic [reeu_pkg::ENC_W-1:0]   r_out_enc;
    logic [1:0]                   r_out_kind;

    // per-encoder and lockout state
    logic [1:0]                   r_last  [reeu_pkg::NUM_ENC];
    logic [reeu_pkg::STEPS_W-1:0] r_fwd   [reeu_pkg::NUM_ENC];
    logic [reeu_pkg::STEPS_W-1:0] r_rev   [reeu_pkg::NUM_ENC];
    logic                         r_lock_active;
    logic [reeu_pkg::TICKS_W-1:0] r_lock_elapsed;

    // next values from the update logic
    logic [reeu_pkg::STEPS_W-1:0] n_fwd;
    logic [reeu_pkg::STEPS_W-1:0] n_rev;
    logic                         n_phase_wr;
    logic                         n_lock_active;
    logic [reeu_pkg::TICKS_W-1:0] n_lock_elapsed;
    logic                         n_evt;
    logic [1:0]                   n_kind;

    logic advance;
    logic enc_ok;

    // input stage moves on when the result stage is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign enc_ok = (32'(r_in_enc) < reeu_pkg::NUM_ENC);

    always_comb begin
        logic [1:0]                   prev;
        logic [reeu_pkg::STEPS_W-1:0] need;
        logic [reeu_pkg::STEPS_W-1:0] f;
        logic [reeu_pkg::STEPS_W-1:0] r;
        logic [reeu_pkg::TICKS_W-1:0] el;

        prev = r_last[r_in_enc];
        need = (r_steps == '0) ? reeu_pkg::STEPS_W'(1) : r_steps;
        f    = r_fwd[r_in_enc];
        r    = r_rev[r_in_enc];
        el   = r_lock_elapsed + 1'b1;

        n_phase_wr     = 1'b0;
        n_lock_active  = r_lock_active;
        n_lock_elapsed = r_lock_elapsed;
        n_evt          = 1'b0;
        n_kind         = reeu_pkg::KIND_SWITCH;

        case (r_in_type)
            reeu_pkg::REQ_PHASE: begin
                if (enc_ok) begin
                    n_phase_wr = 1'b1;
                    if (reeu_pkg::next_fwd(prev) == r_in_code) begin
                        f = reeu_pkg::bump(f);
                        r = '0;
                    end else if (reeu_pkg::next_fwd(r_in_code) == prev) begin
                        r = reeu_pkg::bump(r);
                        f = '0;
                    end
                    // clockwise wins when both counts are at the threshold
                    if (f >= need) begin
                        f      = '0;
                        n_evt  = 1'b1;
                        n_kind = reeu_pkg::KIND_CW;
                    end else if (r >= need) begin
                        r      = '0;
                        n_evt  = 1'b1;
                        n_kind = reeu_pkg::KIND_CCW;
                    end
                end
            end
            reeu_pkg::REQ_PRESS: begin
                if (enc_ok && !r_lock_active) begin
                    n_lock_active  = 1'b1;
                    n_lock_elapsed = '0;
                    n_evt          = 1'b1;
                    n_kind         = reeu_pkg::KIND_SWITCH;
                end
            end
            reeu_pkg::REQ_TICK: begin
                if (r_lock_active) begin
                    if (el >= r_ticks) begin
                        n_lock_active  = 1'b0;
                        n_lock_elapsed = '0;
                    end else begin
                        n_lock_elapsed = el;
                    end
                end
            end
            default: begin
                // unused request type: dropped
            end
        endcase

        n_fwd = f;
        n_rev = r;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= reeu_pkg::STEPS_RST;
            r_ticks <= reeu_pkg::TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                reeu_pkg::CFG_IDX_STEPS:   r_steps <= i_cfg_data[reeu_pkg::STEPS_W-1:0];
                reeu_pkg::CFG_IDX_LOCKOUT: r_ticks <= i_cfg_data[reeu_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_type <= s_axis_tuser;
            r_in_enc  <= s_axis_tdata[0];
            r_in_code <= s_axis_tdata[2:1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_evt;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_evt) begin
            r_out_enc  <= r_in_enc;
            r_out_kind <= n_kind;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < reeu_pkg::NUM_ENC; i++) begin
                r_last[i] <= '0;
                r_fwd[i]  <= '0;
                r_rev[i]  <= '0;
            end
            r_lock_active  <= 1'b0;
            r_lock_elapsed <= '0;
        end else if (advance) begin
            if (n_phase_wr) begin
                r_last[r_in_enc] <= r_in_code;
                r_fwd[r_in_enc]  <= n_fwd;
                r_rev[r_in_enc]  <= n_rev;
            end
            r_lock_active  <= n_lock_active;
            r_lock_elapsed <= n_lock_elapsed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_enc};
    assign m_axis_tuser  = r_out_kind;

    // lockout counter sits at zero whenever the lockout is off
    a_lock_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lock_active |-> (r_lock_elapsed == '0))
        else $error("lockout counter running while lockout inactive");

    // a request held in the input stage is not lost while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("stalled request dropped from input stage");

    // every switch event leaves the lockout running
    a_switch_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_evt && (n_kind == reeu_pkg::KIND_SWITCH)) |=> r_lock_active)
        else $error("switch event issued without starting lockout");

    // only one direction count can be non-zero per encoder
    for (genvar g = 0; g < reeu_pkg::NUM_ENC; g++) begin : g_dir_chk
        a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_fwd[g] == '0) || (r_rev[g] == '0))
            else $error("forward and reverse counts both non-zero");
    end

endmodule
